/* rtl/clnw_pkg.sv */
package clnw_pkg;

   localparam int KIND_W = 2;
   localparam int STEP_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int TASK_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_INIT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_HIGH_MS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_MS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_CMD_MS = 2'd2;

   localparam logic [7:0] LONG_CMD_MS_RESET = 8'd2;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME = 8'h02;
   localparam logic [7:0] CURSOR_BASE = 8'h80;
   localparam logic [7:0] CURSOR_ROW1 = 8'h40;

   localparam logic [7:0] INIT_PRE_WAIT_MS = 8'd25;
   localparam logic [7:0] INIT_FIRST_WAIT_MS = 8'd8;
   localparam logic [7:0] INIT_NEXT_WAIT_MS = 8'd1;
   localparam logic [STEP_W-1:0] INIT_CLEAR_LOW_STEP = 4'd9;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0] byte_value;
      logic row;
      logic [3:0] col;
   } req_type;

   typedef struct packed {
      logic [7:0] pre_wait_ms;
      logic reg_select;
      logic [3:0] nibble;
      logic [7:0] extra_wait_ms;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic is_init;
      logic reg_select;
      logic [7:0] byte_value;
      logic long_wait;
   } task_type;

   // Nibbles of the power-up run: four raw nibbles, then five commands.
   function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
      logic [3:0] nib;
      case (step) inside
         4'd0, 4'd1, 4'd2: nib = 4'h3;
         4'd3: nib = 4'h2;
         4'd4: nib = 4'h2;
         4'd5: nib = 4'h8;
         4'd6: nib = 4'h0;
         4'd7: nib = 4'h8;
         4'd8: nib = 4'h0;
         4'd9: nib = 4'h1;
         4'd10: nib = 4'h0;
         4'd11: nib = 4'h6;
         4'd12: nib = 4'h0;
         4'd13: nib = 4'hC;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

   function automatic logic [7:0] init_extra(input logic [STEP_W-1:0] step,
                                             input logic [7:0] long_ms);
      logic [7:0] extra;
      case (step) inside
         4'd0: extra = INIT_FIRST_WAIT_MS;
         4'd1, 4'd2, 4'd3: extra = INIT_NEXT_WAIT_MS;
         INIT_CLEAR_LOW_STEP: extra = long_ms;
         default: extra = 8'd0;
      endcase
      return extra;
   endfunction

endpackage

/* rtl/char_lcd_nibble_writer.sv */
// Turns each request word into a run of 4-bit enable-pulse words for a character LCD
// driven in 4-bit mode. A command, data or set-cursor request gives two pulse words,
// high nibble first; an initialise request gives fourteen. The pulse sequencer emits
// one pulse word per clock while the result queue has room, and loads the next task
// as it sends the last word of the current one. A short task queue in front of the
// sequencer and a result queue behind it let requests and result pops stall
// independently. Only the long-command wait register affects the pulse words; writes
// to the enable-high and settle registers are accepted and have no effect here.
module char_lcd_nibble_writer #(
   parameter int TASK_DEPTH = clnw_pkg::TASK_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = clnw_pkg::RSP_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   input clnw_pkg::req_type req_word,
   output logic full,
   output logic empty,
   input logic pop,
   output clnw_pkg::rsp_type rsp_word,
   input logic csr_write,
   input logic [clnw_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [clnw_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [7:0] long_cmd_ms_ff, long_cmd_ms_in;
   clnw_pkg::task_type front_task, queue_task;
   logic task_empty, task_pop;
   logic out_full, out_push;
   clnw_pkg::rsp_type out_word;

   always_comb begin
      long_cmd_ms_in = long_cmd_ms_ff;
      if (csr_write && (csr_index == clnw_pkg::CSR_LONG_CMD_MS)) begin
         long_cmd_ms_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_cmd_ms_ff <= clnw_pkg::LONG_CMD_MS_RESET;
      end else begin
         long_cmd_ms_ff <= long_cmd_ms_in;
      end
   end

   clnw_front u_front (
      .req_word(req_word),
      .task_word(front_task)
   );

   clnw_fifo #(
      .DEPTH(TASK_DEPTH),
      .word_type(clnw_pkg::task_type)
   ) u_task_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_word(front_task),
      .full(full),
      .pop(task_pop),
      .pop_word(queue_task),
      .empty(task_empty)
   );

   clnw_back u_back (
      .clock(clock),
      .reset(reset),
      .long_cmd_ms(long_cmd_ms_ff),
      .task_empty(task_empty),
      .task_word(queue_task),
      .task_pop(task_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_word(out_word)
   );

   clnw_fifo #(
      .DEPTH(RSP_DEPTH),
      .word_type(clnw_pkg::rsp_type)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_word(out_word),
      .full(out_full),
      .pop(pop),
      .pop_word(rsp_word),
      .empty(empty)
   );

endmodule

/* rtl/clnw_fifo.sv */
module clnw_fifo #(
   parameter int DEPTH = 2,
   parameter type word_type = logic
) (
   input logic clock,
   input logic reset,
   input logic push,
   input word_type push_word,
   output logic full,
   input logic pop,
   output word_type pop_word,
   output logic empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_word = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* rtl/clnw_front.sv */
module clnw_front (
   input clnw_pkg::req_type req_word,
   output clnw_pkg::task_type task_word
);

   logic [7:0] byte_sel;

   always_comb begin
      task_word.is_init = 1'b0;
      task_word.reg_select = 1'b0;
      byte_sel = req_word.byte_value;
      unique case (req_word.kind)
         clnw_pkg::KIND_COMMAND: begin
            byte_sel = req_word.byte_value;
         end
         clnw_pkg::KIND_DATA: begin
            task_word.reg_select = 1'b1;
         end
         clnw_pkg::KIND_CURSOR: begin
            byte_sel = clnw_pkg::CURSOR_BASE | (req_word.row ? clnw_pkg::CURSOR_ROW1 : 8'h00)
                       | {4'h0, req_word.col};
         end
         clnw_pkg::KIND_INIT: begin
            task_word.is_init = 1'b1;
         end
         default: begin
            task_word.is_init = 1'b0;
         end
      endcase
      task_word.byte_value = byte_sel;
      // Only commands get the long wait; a data byte of the same value does not.
      task_word.long_wait = !task_word.reg_select
                            && ((byte_sel == clnw_pkg::CMD_CLEAR)
                                || (byte_sel == clnw_pkg::CMD_HOME));
   end

endmodule

/* rtl/clnw_back.sv */
module clnw_back (
   input logic clock,
   input logic reset,
   input logic [7:0] long_cmd_ms,
   input logic task_empty,
   input clnw_pkg::task_type task_word,
   output logic task_pop,
   input logic out_full,
   output logic out_push,
   output clnw_pkg::rsp_type out_word
);

   logic active_ff, active_in;
   clnw_pkg::task_type task_ff, task_in;
   logic [clnw_pkg::STEP_W-1:0] step_ff, step_in;
   logic finish, load;

   always_comb begin
      out_word = '0;
      if (task_ff.is_init) begin
         out_word.pre_wait_ms = (step_ff == '0) ? clnw_pkg::INIT_PRE_WAIT_MS : 8'd0;
         out_word.reg_select = 1'b0;
         out_word.nibble = clnw_pkg::init_nibble(step_ff);
         out_word.extra_wait_ms = clnw_pkg::init_extra(step_ff, long_cmd_ms);
         out_word.last = (step_ff == clnw_pkg::INIT_LAST_STEP);
      end else begin
         out_word.pre_wait_ms = 8'd0;
         out_word.reg_select = task_ff.reg_select;
         out_word.nibble = step_ff[0] ? task_ff.byte_value[3:0] : task_ff.byte_value[7:4];
         out_word.extra_wait_ms = (step_ff[0] && task_ff.long_wait) ? long_cmd_ms : 8'd0;
         out_word.last = step_ff[0];
      end
   end

   assign out_push = active_ff && !out_full;
   assign finish = out_push && out_word.last;
   assign load = !task_empty && (!active_ff || finish);
   assign task_pop = load;

   always_comb begin
      active_in = active_ff;
      task_in = task_ff;
      step_in = step_ff;
      if (load) begin
         active_in = 1'b1;
         task_in = task_word;
         step_in = '0;
      end else if (finish) begin
         active_in = 1'b0;
      end else if (out_push) begin
         step_in = step_ff + clnw_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         active_ff <= active_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
   end

endmodule
